### hw/rtl/hoi_pkg.sv
package hoi_pkg;

  localparam int Wheels = 3;
  localparam int CordicSteps = 24;
  localparam int AtanEntries = 30;
  localparam int NumRegs = 2 * Wheels;

  localparam logic signed [31:0] TwoPiQ24 = 32'sd105414357;
  localparam logic signed [31:0] PiQ24 = 32'sd52707179;
  localparam logic signed [31:0] HalfPiQ24 = 32'sd26353589;
  localparam logic signed [33:0] CordicGainQ30 = 34'sd652032874;
  localparam int ScaleDiv = 1000;

  // register indexes
  localparam logic [2:0] RegDx0 = 3'd0;
  localparam logic [2:0] RegDx1 = 3'd1;
  localparam logic [2:0] RegDx2 = 3'd2;
  localparam logic [2:0] RegDy0 = 3'd3;
  localparam logic [2:0] RegDy1 = 3'd4;
  localparam logic [2:0] RegDy2 = 3'd5;

  // input tdata layout widths
  localparam int InDataW = 16 * 3 + 32 * 4;
  localparam int OutDataW = 96;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0: atan_q30 = 34'sd843314857;
      5'd1: atan_q30 = 34'sd497837829;
      5'd2: atan_q30 = 34'sd263043837;
      5'd3: atan_q30 = 34'sd133525159;
      5'd4: atan_q30 = 34'sd67021687;
      5'd5: atan_q30 = 34'sd33543516;
      5'd6: atan_q30 = 34'sd16775851;
      5'd7: atan_q30 = 34'sd8388437;
      5'd8: atan_q30 = 34'sd4194283;
      5'd9: atan_q30 = 34'sd2097149;
      default: atan_q30 = 34'sd1 <<< (5'd30 - i);
    endcase
  endfunction

endpackage

### hw/rtl/hoi_serial_mul.sv
// signed multiplier: one bit of the multiplier per cycle (shift and add)
module hoi_serial_mul (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [33:0]  a,
  input  logic signed [33:0]  b,
  output logic                done,
  output logic signed [67:0]  product
);
  import hoi_pkg::*;

  logic        [33:0] mplr;
  logic signed [67:0] mcand;
  logic signed [67:0] acc;
  logic        [5:0]  cnt;
  logic               busy;

  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        mplr <= b;
        mcand <= 68'(a);
        acc <= '0;
      end else if (busy) begin
        // top bit of a two's complement multiplier has negative weight
        if (mplr[0]) begin
          if (cnt == 6'd33) acc <= acc - mcand;
          else acc <= acc + mcand;
        end
        mplr <= mplr >> 1;
        mcand <= mcand <<< 1;
        cnt <= cnt + 6'd1;
        if (cnt == 6'd33) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### hw/rtl/holonomic_odometry_integrator.sv
// holonomic odometry integrator
// input stream s_axis: one item per encoder update or position load.
//   tuser carries mode (1 = load x, y, heading directly).
// output stream m_axis: one item per input item with x, y, heading, and
//   tuser = saturated flag, held in an output register.
// apb port writes the six Q16.16 matrix coefficients at 4*i.
// a load item or the first update after reset: the item goes through the
// output state into the output register; no new item is taken until then.
// an encoder update: six matrix products, the divide by 1000 for dx and
// dy, 0 to 20 steps of 2*pi to reduce the stored heading, the cordic
// and four rotation products, in that order, with no new item taken
// meanwhile; the products run on a shared 34x34 shift-add multiplier.
// reset clears position and heading to zero and rearms the first-update
// latch; coefficients reset to zero.
// when the receiver stalls the result waits in the output register; the
// next item is taken meanwhile and waits for the register when done.
module holonomic_odometry_integrator (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // count_wheel0, count_wheel1, count_wheel2, gyro_heading, load_x,
  // load_y, load_heading
  input  logic [175:0] s_axis_tdata,
  // mode
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x, pos_y, heading
  output logic [95:0]  m_axis_tdata,
  // saturated
  output logic         m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import hoi_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_START, S_MUL_WAIT, S_DIV, S_RED, S_CORDIC,
    S_ROT_START, S_ROT_WAIT, S_FINISH, S_OUT
  } state_t;

  state_t state;

  // configuration
  logic signed [31:0] coef [NumRegs];
  logic [2:0] reg_idx;
  assign pready = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) coef[i] <= '0;
    end else if (psel && penable && pwrite && paddr[4:2] <= RegDy2) begin
      coef[reg_idx] <= pwdata;
    end
  end

  always_comb begin
    case (reg_idx)
      RegDx0, RegDx1, RegDx2, RegDy0, RegDy1, RegDy2: prdata = coef[reg_idx];
      default: prdata = '0;
    endcase
  end

  // architectural state
  logic signed [31:0] acc_x, acc_y, acc_heading;
  logic signed [15:0] last_counts [Wheels];
  logic awaiting_first;

  // working registers
  logic signed [16:0] diff [Wheels];
  logic signed [31:0] gyro;
  logic [2:0] mstep;          // product index
  logic signed [67:0] sum;    // accumulated matrix or rotation sum
  logic signed [67:0] sx;
  logic signed [33:0] dx, dy;
  logic sat;
  logic signed [33:0] cx, cy, cz;
  logic cflip;
  logic [4:0] cstep;
  logic [1:0] rstep;
  logic signed [67:0] rx;

  // shared serial multiplier
  logic mul_start, mul_done;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;

  hoi_serial_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .product(mul_p)
  );

  // restoring divider on magnitude, one quotient bit per cycle
  logic [63:0] dv_num;
  logic [10:0] dv_rem;
  logic [6:0] dv_cnt;
  logic dv_neg, dv_second;
  logic [10:0] dv_trial;
  logic [11:0] dv_sub;
  assign dv_trial = {dv_rem[9:0], dv_num[63]};
  assign dv_sub = {1'b0, dv_trial} - 12'(ScaleDiv);

  // operand select for the multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_MUL_START) begin
      mul_a = 34'(coef[mstep]);
      case (mstep)
        3'd0, 3'd3: mul_b = 34'(diff[0]);
        3'd1, 3'd4: mul_b = 34'(diff[1]);
        default: mul_b = 34'(diff[2]);
      endcase
    end else begin
      case (rstep)
        2'd0: begin mul_a = dx; mul_b = cx; end
        2'd1: begin mul_a = dy; mul_b = cy; end
        2'd2: begin mul_a = dx; mul_b = cy; end
        default: begin mul_a = dy; mul_b = cx; end
      endcase
    end
  end
  assign mul_start = (state == S_MUL_START) || (state == S_ROT_START);

  // clip of a quotient or a position sum to 32 bits
  function automatic logic signed [33:0] clip_q(input logic signed [64:0] v,
                                                 output logic c);
    logic signed [64:0] hi, lo;
    begin
      hi = 65'sd2147483647;
      lo = -65'sd2147483648;
      c = 1'b0;
      clip_q = 34'(v);
      if (v > hi) begin c = 1'b1; clip_q = 34'sd2147483647; end
      if (v < lo) begin c = 1'b1; clip_q = -34'sd2147483648; end
    end
  endfunction

  // heading reduction: modulo by conditional subtracts or adds of 2*pi over cycles
  logic signed [33:0] red;
  logic signed [33:0] sh_x, sh_y;
  assign sh_x = cx >>> cstep;
  assign sh_y = cy >>> cstep;

  logic signed [64:0] q_signed;
  logic c_sat;
  logic signed [33:0] q_clip;
  logic signed [68:0] pos_sum;
  logic signed [68:0] rnd;
  logic signed [33:0] new_pos;
  logic p_sat;

  always_comb begin
    q_signed = dv_neg ? -$signed({1'b0, dv_num}) : $signed({1'b0, dv_num});
    q_clip = clip_q(q_signed, c_sat);
    rnd = (69'(sum) + (69'sd1 <<< 29)) >>> 30;
    pos_sum = (rstep[1] ? 69'(acc_y) : 69'(acc_x)) + rnd;
    new_pos = clip_q(65'(pos_sum), p_sat);
  end

  logic [1:0] red_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      acc_x <= '0;
      acc_y <= '0;
      acc_heading <= '0;
      awaiting_first <= 1'b1;
      m_axis_tvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            gyro <= s_axis_tdata[79:48];
            sat <= 1'b0;
            for (int i = 0; i < Wheels; i++) begin
              diff[i] <= 17'($signed(s_axis_tdata[16*i +: 16]))
                         - 17'(last_counts[i]);
            end
            if (s_axis_tuser) begin
              acc_x <= s_axis_tdata[111:80];
              acc_y <= s_axis_tdata[143:112];
              acc_heading <= s_axis_tdata[175:144];
              state <= S_OUT;
            end else begin
              for (int i = 0; i < Wheels; i++)
                last_counts[i] <= s_axis_tdata[16*i +: 16];
              if (awaiting_first) begin
                awaiting_first <= 1'b0;
                state <= S_OUT;
              end else begin
                mstep <= '0;
                sum <= '0;
                state <= S_MUL_START;
              end
            end
          end
        end
        S_MUL_START: state <= S_MUL_WAIT;
        S_MUL_WAIT: begin
          if (mul_done) begin
            if (mstep == 3'd2) begin
              sx <= sum + mul_p;
              sum <= '0;
              mstep <= mstep + 3'd1;
              state <= S_MUL_START;
            end else if (mstep == 3'd5) begin
              // divide dx first
              dv_neg <= sx[67];
              dv_num <= sx[67] ? 64'(-sx) : 64'(sx);
              sum <= sum + mul_p;
              dv_rem <= '0;
              dv_cnt <= '0;
              dv_second <= 1'b0;
              state <= S_DIV;
            end else begin
              sum <= sum + mul_p;
              mstep <= mstep + 3'd1;
              state <= S_MUL_START;
            end
          end
        end
        S_DIV: begin
          if (dv_cnt == 7'd64) begin
            if (!dv_second) begin
              dx <= q_clip;
              sat <= sat | c_sat;
              dv_neg <= sum[67];
              dv_num <= sum[67] ? 64'(-sum) : 64'(sum);
              dv_rem <= '0;
              dv_cnt <= '0;
              dv_second <= 1'b1;
            end else begin
              dy <= q_clip;
              sat <= sat | c_sat;
              red <= 34'(acc_heading);
              red_phase <= '0;
              state <= S_RED;
            end
          end else begin
            if (!dv_sub[11]) begin
              dv_rem <= dv_sub[10:0];
              dv_num <= {dv_num[62:0], 1'b1};
            end else begin
              dv_rem <= dv_trial;
              dv_num <= {dv_num[62:0], 1'b0};
            end
            dv_cnt <= dv_cnt + 7'd1;
          end
        end
        S_RED: begin
          // |heading| < 21*2pi: step by 2pi toward [-pi, pi)
          if (red >= 34'(PiQ24)) red <= red - 34'(TwoPiQ24);
          else if (red < -34'(PiQ24)) red <= red + 34'(TwoPiQ24);
          else if (red_phase == 2'd0) begin
            // fold into [-pi/2, pi/2] with a sign flip of the result
            red_phase <= 2'd1;
            if (red > 34'(HalfPiQ24)) begin
              red <= red - 34'(PiQ24);
              cflip <= 1'b1;
            end else if (red < -34'(HalfPiQ24)) begin
              red <= red + 34'(PiQ24);
              cflip <= 1'b1;
            end else begin
              cflip <= 1'b0;
            end
          end else begin
            cz <= red <<< 6;
            cx <= CordicGainQ30;
            cy <= '0;
            cstep <= '0;
            state <= S_CORDIC;
          end
        end
        S_CORDIC: begin
          if (cstep == 5'(CordicSteps)) begin
            if (cflip) begin
              cx <= -cx;
              cy <= -cy;
            end
            rstep <= '0;
            sum <= '0;
            state <= S_ROT_START;
          end else begin
            if (!cz[33]) begin
              cx <= cx - sh_y;
              cy <= cy + sh_x;
              cz <= cz - atan_q30(cstep);
            end else begin
              cx <= cx + sh_y;
              cy <= cy - sh_x;
              cz <= cz + atan_q30(cstep);
            end
            cstep <= cstep + 5'd1;
          end
        end
        S_ROT_START: state <= S_ROT_WAIT;
        S_ROT_WAIT: begin
          if (mul_done) begin
            case (rstep)
              2'd0: begin rx <= mul_p; rstep <= 2'd1; state <= S_ROT_START; end
              2'd1: begin
                sum <= rx - mul_p;
                state <= S_FINISH;
              end
              2'd2: begin rx <= mul_p; rstep <= 2'd3; state <= S_ROT_START; end
              default: begin
                sum <= rx + mul_p;
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_FINISH: begin
          // x after the first rotation pair, y after the second
          sat <= sat | p_sat;
          if (rstep == 2'd1) begin
            acc_x <= new_pos[31:0];
            rstep <= 2'd2;
            state <= S_ROT_START;
          end else begin
            acc_y <= new_pos[31:0];
            acc_heading <= gyro;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // leave once the output register takes the item
          if (!m_axis_tvalid || m_axis_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase

      // output register: loaded from the output state, emptied by the receiver
      if (state == S_OUT && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata <= {acc_heading, acc_y, acc_x};
        m_axis_tuser <= sat;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  assign s_axis_tready = (state == S_IDLE);

  // checks
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser)) else $error("result changed while stalled");
  a_out_waits: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && m_axis_tvalid && !m_axis_tready |=> state == S_OUT)
    else $error("finished item left while output register full");
  a_first_clears: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && !s_axis_tuser && awaiting_first)
      |=> !awaiting_first) else $error("first update did not clear latch");

endmodule

### dv/tb_holonomic_odometry_integrator.sv
`timescale 1ns / 1ps

module tb_holonomic_odometry_integrator;
  import hoi_pkg::*;

  localparam int NumUpdates = 1550;
  localparam int DrainCycles = 600;

  // one result item
  typedef struct packed {
    logic        saturated;
    logic [31:0] heading;
    logic [31:0] pos_y;
    logic [31:0] pos_x;
  } pose_t;

  // one input item
  typedef struct {
    logic               mode;
    logic signed [15:0] count[3];
    logic signed [31:0] gyro;
    logic signed [31:0] ld_x;
    logic signed [31:0] ld_y;
    logic signed [31:0] ld_heading;
  } odo_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [175:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic m_axis_tuser;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  int err_count = 0;
  int stall_mode = 0;
  bit no_stall = 1'b0;

  always #1 clk = ~clk;

  holonomic_odometry_integrator i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // odometry predictor and queue of expected poses
  class pose_tracker;
    logic signed [31:0] coef[6];
    logic signed [31:0] px, py, ph;
    logic signed [16:0] prev_count[3];
    bit first_pending;
    pose_t pending[$];

    function new();
      foreach (coef[i]) coef[i] = '0;
      px = '0; py = '0; ph = '0;
      first_pending = 1'b1;
      foreach (prev_count[i]) prev_count[i] = '0;
    endfunction

    function automatic logic signed [63:0] clip(input logic signed [63:0] v,
                                                inout bit sat);
      if (v > 64'sd2147483647) begin
        sat = 1; return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        sat = 1; return -64'sd2147483648;
      end
      return v;
    endfunction

    // cordic rotation of the gain-compensated unit vector
    function automatic void rotate_unit(input logic signed [31:0] ang,
                                        output logic signed [63:0] c,
                                        output logic signed [63:0] s);
      logic signed [63:0] r, x, y, z, nx, step;
      bit flip;
      r = 64'(ang) % 64'(TwoPiQ24);
      flip = 0;
      if (r < 0) r += 64'(TwoPiQ24);
      if (r >= 64'(PiQ24)) r -= 64'(TwoPiQ24);
      if (r > 64'(HalfPiQ24)) begin
        r -= 64'(PiQ24); flip = 1;
      end else if (r < -64'(HalfPiQ24)) begin
        r += 64'(PiQ24); flip = 1;
      end
      x = 64'(CordicGainQ30);
      y = '0;
      z = r * 64;
      for (int i = 0; i < CordicSteps && i < AtanEntries; i++) begin
        step = (i < 10) ? 64'(atan_tab(i)) : (64'sd1 <<< (30 - i));
        if (z >= 0) begin
          nx = x - (y >>> i); y = y + (x >>> i); z -= step;
        end else begin
          nx = x + (y >>> i); y = y - (x >>> i); z += step;
        end
        x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function automatic int atan_tab(input int i);
      int t[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                    33543516, 16775851, 8388437, 4194283, 2097149};
      return t[i];
    endfunction

    function void write_coef(input int idx, input logic [31:0] v);
      if (idx < 6) coef[idx] = v;
    endfunction

    function void note_input(input odo_item_t it);
      bit sat;
      logic signed [63:0] sx, sy, d, dx, dy, c, s, mx, my;
      pose_t p;
      sat = 0;
      if (it.mode) begin
        px = it.ld_x; py = it.ld_y; ph = it.ld_heading;
      end else if (first_pending) begin
        foreach (prev_count[i]) prev_count[i] = it.count[i];
        first_pending = 0;
      end else begin
        sx = 0; sy = 0;
        for (int i = 0; i < 3; i++) begin
          d = 64'(it.count[i]) - 64'(prev_count[i]);
          prev_count[i] = it.count[i];
          sx += 64'(coef[i]) * d;
          sy += 64'(coef[3 + i]) * d;
        end
        dx = clip(sx / 1000, sat);
        dy = clip(sy / 1000, sat);
        rotate_unit(ph, c, s);
        mx = (dx * c - dy * s + (64'sd1 <<< 29)) >>> 30;
        my = (dx * s + dy * c + (64'sd1 <<< 29)) >>> 30;
        px = 32'(clip(64'(px) + mx, sat));
        py = 32'(clip(64'(py) + my, sat));
        ph = it.gyro;
      end
      p.pos_x = px; p.pos_y = py; p.heading = ph; p.saturated = sat;
      pending.push_back(p);
    endfunction

    task check_pose(input pose_t got);
      pose_t w;
      if (pending.size() == 0) begin
        report_mismatch("unexpected item", got.pos_x, '0);
        return;
      end
      w = pending.pop_front();
      if (got.pos_x !== w.pos_x) report_mismatch("pos_x", got.pos_x, w.pos_x);
      if (got.pos_y !== w.pos_y) report_mismatch("pos_y", got.pos_y, w.pos_y);
      if (got.heading !== w.heading) report_mismatch("heading", got.heading, w.heading);
      if (got.saturated !== w.saturated)
        report_mismatch("saturated", 32'(got.saturated), 32'(w.saturated));
    endtask
  endclass

  pose_tracker tracker = new();

  // receiver with its own stall pattern
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      tracker.check_pose(pose_t'({m_axis_tuser, m_axis_tdata}));
    if (no_stall) begin
      m_axis_tready <= 1'b1;
    end else begin
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // cycle the stall pattern now and then
  always @(posedge clk) begin
    if ($urandom_range(0, 999) == 0) stall_mode <= $urandom_range(0, 2);
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    tracker.write_coef(idx, v);
    @(posedge clk);
  endtask

  task automatic send_item(input odo_item_t it);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.mode;
    s_axis_tdata <= {it.ld_heading, it.ld_y, it.ld_x, it.gyro,
                     it.count[2], it.count[1], it.count[0]};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    tracker.note_input(it);
  endtask

  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 9);
    if (n > 5) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  endtask

  function automatic odo_item_t rand_item(input int cnt_span);
    odo_item_t it;
    it.mode = ($urandom_range(0, 15) == 0);
    for (int i = 0; i < 3; i++)
      it.count[i] = (cnt_span == 0) ? 16'($urandom) :
                    16'($urandom_range(0, 2 * cnt_span) - cnt_span);
    it.gyro = $urandom;
    it.ld_x = ($urandom_range(0, 1)) ? $urandom : 32'($urandom_range(0, 200000) - 100000);
    it.ld_y = ($urandom_range(0, 1)) ? $urandom : 32'($urandom_range(0, 200000) - 100000);
    it.ld_heading = $urandom;
    return it;
  endfunction

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic load_coefs(input logic [31:0] v[6]);
    for (int i = 0; i < 6; i++) write_reg(3'(i), v[i]);
  endtask

  initial begin
    odo_item_t it;
    logic [31:0] cv[6];
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: moderate matrix, extremes of counts and headings
    cv = '{32'sd65536, -32'sd32768, 32'sd12345, 32'sd0, 32'sd70000, -32'sd65536};
    load_coefs(cv);
    it = rand_item(100); it.mode = 0;
    it.count = '{16'sh7fff, 16'sh8000, 16'sh0000};
    send_item(it);
    it.count = '{16'sh8000, 16'sh7fff, 16'shffff};
    it.gyro = 32'h7fffffff; send_item(it);
    it.count = '{16'sh7fff, 16'sh8000, 16'sh0001};
    it.gyro = 32'h80000000; send_item(it);
    it.gyro = PiQ24; send_item(it);
    it.gyro = -PiQ24; send_item(it);
    it.gyro = HalfPiQ24; send_item(it);
    it.gyro = -HalfPiQ24 - 1; send_item(it);
    it.gyro = TwoPiQ24; send_item(it);
    it.mode = 1; it.ld_x = 32'h7fffff00; it.ld_y = 32'h80000100;
    it.ld_heading = 32'h7fffffff; send_item(it);
    it.mode = 0; it.count = '{16'sh8000, 16'sh7fff, 16'sh8000}; send_item(it);
    it.mode = 1; it.ld_x = 32'h80000000; it.ld_y = 32'h7fffffff;
    it.ld_heading = 32'h80000000; send_item(it);
    it.mode = 0; it.count = '{16'sh7fff, 16'sh8000, 16'sh7fff}; send_item(it);
    wait_drained();

    // directed: extreme coefficients clip dx and dy
    cv = '{32'h7fffffff, 32'h80000000, 32'h7fffffff,
           32'h80000000, 32'h7fffffff, 32'h80000000};
    load_coefs(cv);
    it.mode = 0; it.count = '{16'sh8000, 16'sh7fff, 16'sh8000}; it.gyro = 0;
    send_item(it);
    it.count = '{16'sh7fff, 16'sh8000, 16'sh7fff}; send_item(it);
    it.mode = 1; it.ld_x = 0; it.ld_y = 0; it.ld_heading = 0; send_item(it);
    it.mode = 0; it.count = '{16'sh0000, 16'sh0000, 16'sh0000}; send_item(it);
    wait_drained();

    // random phases over several coefficient settings
    for (int ph = 0; ph < 8; ph++) begin
      for (int i = 0; i < 6; i++)
        case (ph % 4)
          0: cv[i] = $urandom;
          1: cv[i] = 32'($urandom_range(0, 400000) - 200000);
          2: cv[i] = (ph == 2) ? 32'h0 : 32'($urandom_range(0, 4000) - 2000);
          default: cv[i] = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
        endcase
      load_coefs(cv);
      for (int n = 0; n < NumUpdates / 8; n++) begin
        no_stall <= (ph == 4 && n < 40);
        send_item(rand_item((ph % 2) ? 0 : 300));
        if (!(ph == 5 && n < 60)) idle_gap();
      end
      wait_drained();
    end

    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // hard stop for a hung handshake
  initial begin
    #20000000;
    $display("status: fail");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/hoi_pkg.sv
hw/rtl/hoi_serial_mul.sv
hw/rtl/holonomic_odometry_integrator.sv
dv/tb_holonomic_odometry_integrator.sv
